FILE: hw/rtl/min_coin_change_dp_core_macros.svh
// assertion macros shared by the coin change core
`ifndef MIN_COIN_CHANGE_DP_CORE_MACROS_SVH
`define MIN_COIN_CHANGE_DP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check held off while reset is high
`define MCC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("coin change core check failed");
// check that also runs through reset
`define MCC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("coin change core reset check failed");
`else
`define MCC_ASSERT(lbl, clk, rst, prop)
`define MCC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/mcc_pkg.sv
`timescale 1ns / 1ps
package mcc_pkg;

  localparam int MAX_AMOUNT_DEF = 255;
  localparam int NUM_COINS_DEF  = 6;
  localparam int MAX_COINS      = 6;
  localparam int VAL_W          = 8;
  localparam int CNT_W          = 9;
  localparam int SEL_W          = 3;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t COUNT_UNSET = '1;

  // one table word: least count and the last coin taken to reach it
  typedef struct packed {
    cnt_t count;
    val_t coin;
  } entry_t;

  typedef enum logic [SEL_W-1:0] {
    REG_COINS_IN_USE = 3'd0,
    REG_COIN_A       = 3'd1,
    REG_COIN_B       = 3'd2,
    REG_COIN_C       = 3'd3,
    REG_COIN_D       = 3'd4,
    REG_COIN_E       = 3'd5,
    REG_COIN_F       = 3'd6
  } reg_idx_t;

  localparam logic [SEL_W-1:0] COINS_IN_USE_RESET = 3'd6;
  localparam val_t COIN_RESET [MAX_COINS] = '{8'd55, 8'd22, 8'd15, 8'd10, 8'd7, 8'd1};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_COIN,
    ST_FILL,
    ST_DRAIN,
    ST_LOOKUP,
    ST_TOTAL,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/mcc_ram.sv
`timescale 1ns / 1ps
module mcc_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mcc_pkg::entry_t wdata,
  input  logic [AW-1:0]   ra_addr,
  input  logic [AW-1:0]   rb_addr,
  output mcc_pkg::entry_t qa,
  output mcc_pkg::entry_t qb
);
  import mcc_pkg::*;

  entry_t mem [DEPTH];

  // write-first: a read of the address being written returns the new word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= (we && waddr == ra_addr) ? wdata : mem[ra_addr];
    qb <= (we && waddr == rb_addr) ? wdata : mem[rb_addr];
  end

endmodule

FILE: hw/rtl/mcc_relax.sv
`timescale 1ns / 1ps
module mcc_relax (
  input  mcc_pkg::entry_t prev,
  input  mcc_pkg::entry_t cur,
  input  mcc_pkg::val_t   coin,
  output logic            improve,
  output mcc_pkg::entry_t upd
);
  import mcc_pkg::*;

  logic [CNT_W:0] cand;

  assign cand    = {1'b0, prev.count} + {{CNT_W{1'b0}}, 1'b1};
  // strict compare keeps the earlier coin on a tie
  assign improve = (prev.count != COUNT_UNSET) && ({1'b0, cur.count} > cand);

  always_comb begin
    upd.count = cand[CNT_W-1:0];
    upd.coin  = coin;
  end

endmodule

FILE: hw/rtl/mcc_tally.sv
`timescale 1ns / 1ps
module mcc_tally #(
  parameter int NUM_COINS = mcc_pkg::NUM_COINS_DEF
) (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       step,
  input  mcc_pkg::val_t              coin,
  input  mcc_pkg::val_t              coin_value [NUM_COINS],
  input  logic [mcc_pkg::SEL_W-1:0]  n_eff,
  output mcc_pkg::val_t              used [NUM_COINS]
);
  import mcc_pkg::*;

  // every active index holding the walked coin value counts it
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_COINS; k++) begin
      if (clear) begin
        used[k] <= '0;
      end else if (step && SEL_W'(k) < n_eff && coin_value[k] == coin && used[k] != '1) begin
        used[k] <= used[k] + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/min_coin_change_dp_core.sv
`timescale 1ns / 1ps
// Fewest-coin change core. Pulse start with amount while busy is low; the
// result appears on used_a..used_f, total_coins and unreachable for exactly one
// cycle with done high, and there is no way to hold it, so the receiver must
// take it then. Denominations and coins_in_use are to be written through wr_en,
// wr_index and wr_data only while busy is low; the block does not enforce it.
// For an amount A the work is one table write per entry 0..A, then for each
// active coin c <= A a pass over entries c..A (a coin of zero or above A is
// skipped), then closing the coin loop, reading the total, reading and
// evaluating each coin in the walk back, and the done state. An amount above
// MAX_AMOUNT goes straight to the done state. Busy drops in the cycle after
// done, and the next start can be taken from then on. The longest case is
// six coins of value one with A = 255. The pace is set by the single
// read-compare-write unit on the count table, one entry per cycle.
`include "min_coin_change_dp_core_macros.svh"
module min_coin_change_dp_core #(
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF,
  parameter int NUM_COINS  = mcc_pkg::NUM_COINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  mcc_pkg::val_t             amount,
  input  logic                      wr_en,
  input  logic [mcc_pkg::SEL_W-1:0] wr_index,
  input  mcc_pkg::val_t             wr_data,
  output logic                      done,
  output mcc_pkg::val_t             used_a,
  output mcc_pkg::val_t             used_b,
  output mcc_pkg::val_t             used_c,
  output mcc_pkg::val_t             used_d,
  output mcc_pkg::val_t             used_e,
  output mcc_pkg::val_t             used_f,
  output mcc_pkg::val_t             total_coins,
  output logic                      unreachable
);
  import mcc_pkg::*;

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
  localparam int XW    = AW + VAL_W;

  state_t state, state_next;

  logic [SEL_W-1:0] coins_in_use;
  val_t             coin_value [NUM_COINS];
  logic [SEL_W-1:0] n_eff;

  val_t             amt;
  logic [AW-1:0]    amt_aw;
  logic [AW-1:0]    j;
  logic [AW-1:0]    m;
  logic [SEL_W-1:0] ci;
  val_t             cur_coin;
  val_t             coin_sel;
  logic             coin_skip;
  logic             amount_ok;

  logic             pv;
  logic [AW-1:0]    pj;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  entry_t           init_entry;
  logic [AW-1:0]    ra_addr;
  entry_t           qa;
  entry_t           qb;

  logic             improve;
  entry_t           upd;

  val_t             wc;
  logic             walk_bad;
  logic [XW-1:0]    m_rem;
  logic             walk_last;
  logic             tally_clear;
  logic             tally_step;
  val_t             tally_used [NUM_COINS];
  val_t             used_all [MAX_COINS];

  val_t             total_q;
  logic             unreach_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coins_in_use <= COINS_IN_USE_RESET;
      for (int k = 0; k < NUM_COINS; k++) begin
        coin_value[k] <= COIN_RESET[k];
      end
    end else if (wr_en) begin
      if (wr_index == REG_COINS_IN_USE) begin
        coins_in_use <= wr_data[SEL_W-1:0];
      end
      for (int k = 0; k < NUM_COINS; k++) begin
        if (wr_index == SEL_W'(REG_COIN_A) + SEL_W'(k)) begin
          coin_value[k] <= wr_data;
        end
      end
    end
  end

  assign n_eff     = (coins_in_use > SEL_W'(NUM_COINS)) ? SEL_W'(NUM_COINS) : coins_in_use;
  assign amt_aw    = AW'(amt);
  assign amount_ok = XW'(amount) <= XW'(MAX_AMOUNT);
  assign coin_sel  = coin_value[ci[IW-1:0]];
  assign coin_skip = (coin_sel == '0) || (coin_sel > amt);

  assign wc        = qa.coin;
  assign walk_bad  = (wc == '0) || (XW'(wc) > XW'(m));
  assign m_rem     = XW'(m) - XW'(wc);
  assign walk_last = walk_bad || (m_rem == '0);

  always_comb begin
    init_entry.count = (j == '0) ? '0 : COUNT_UNSET;
    init_entry.coin  = '0;
  end

  assign ra_addr   = (state == ST_FILL) ? (j - AW'(cur_coin)) : m;
  assign ram_we    = (state == ST_INIT) || (pv && improve);
  assign ram_waddr = (state == ST_INIT) ? j : pj;
  assign ram_wdata = (state == ST_INIT) ? init_entry : upd;

  mcc_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ra_addr),
    .rb_addr (j),
    .qa      (qa),
    .qb      (qb)
  );

  mcc_relax u_relax (
    .prev    (qa),
    .cur     (qb),
    .coin    (cur_coin),
    .improve (improve),
    .upd     (upd)
  );

  assign tally_clear = (state == ST_IDLE) && start;
  assign tally_step  = (state == ST_WALK_EV) && !walk_bad;

  mcc_tally #(
    .NUM_COINS(NUM_COINS)
  ) u_tally (
    .clk        (clk),
    .clear      (tally_clear),
    .step       (tally_step),
    .coin       (wc),
    .coin_value (coin_value),
    .n_eff      (n_eff),
    .used       (tally_used)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = amount_ok ? ST_INIT : ST_DONE;
        end
      end
      ST_INIT: begin
        if (j == amt_aw) state_next = ST_COIN;
      end
      ST_COIN: begin
        if (ci >= n_eff) begin
          state_next = ST_LOOKUP;
        end else if (!coin_skip) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (j == amt_aw) state_next = ST_DRAIN;
      end
      ST_DRAIN:   state_next = ST_COIN;
      ST_LOOKUP:  state_next = ST_TOTAL;
      ST_TOTAL: begin
        if (qa.count == COUNT_UNSET || m == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_next = ST_WALK_EV;
      ST_WALK_EV: state_next = walk_last ? ST_DONE : ST_WALK_RD;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // compare stage runs in the cycle after the fill reads
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == ST_FILL);
    end
    pj <= j;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          amt       <= amount;
          j         <= '0;
          ci        <= '0;
          total_q   <= '0;
          unreach_q <= !amount_ok;
        end
      end
      ST_INIT: j <= j + 1'b1;
      ST_COIN: begin
        if (ci >= n_eff) begin
          m <= amt_aw;
        end else if (coin_skip) begin
          ci <= ci + 1'b1;
        end else begin
          cur_coin <= coin_sel;
          j        <= AW'(coin_sel);
        end
      end
      ST_FILL:  j <= j + 1'b1;
      ST_DRAIN: ci <= ci + 1'b1;
      ST_TOTAL: begin
        if (qa.count == COUNT_UNSET) begin
          unreach_q <= 1'b1;
        end else begin
          total_q <= qa.count[CNT_W-1] ? '1 : qa.count[VAL_W-1:0];
        end
      end
      ST_WALK_EV: begin
        if (!walk_bad) m <= m_rem[AW-1:0];
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < MAX_COINS; k++) begin : g_used
    if (k < NUM_COINS) begin : g_on
      assign used_all[k] = tally_used[k];
    end else begin : g_off
      assign used_all[k] = '0;
    end
  end

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_DONE);
  assign used_a      = used_all[0];
  assign used_b      = used_all[1];
  assign used_c      = used_all[2];
  assign used_d      = used_all[3];
  assign used_e      = used_all[4];
  assign used_f      = used_all[5];
  assign total_coins = total_q;
  assign unreachable = unreach_q;

  `MCC_ASSERT_RST(a_reset_idle, clk, rst |=> (!busy && !done))
  `MCC_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `MCC_ASSERT(a_done_pulse, clk, rst, done |=> !done)
  `MCC_ASSERT(a_unreach_zero, clk, rst, (done && unreachable) |-> ({total_coins, used_a, used_f} == '0))
  `MCC_ASSERT(a_walk_shrinks, clk, rst, (state == ST_WALK_EV && !walk_bad) |=> (m < $past(m)))
  `MCC_ASSERT(a_write_window, clk, rst, ram_we |-> (state == ST_INIT || state == ST_FILL || state == ST_DRAIN))

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mcc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int UNSET_COUNT = 32'h0000_FFFF;
  localparam logic [SEL_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    val_t [MAX_COINS-1:0] used;
    val_t total;
    logic unreach;
  } change_t;

  class coin_change_board;
    logic [SEL_W-1:0] coins_sel;
    val_t denom [MAX_COINS];
    int unsigned least_cnt [MAX_AMOUNT_DEF+1];
    int unsigned last_coin [MAX_AMOUNT_DEF+1];
    change_t pending_change [$];
    int mismatches;

    function new();
      coins_sel = COINS_IN_USE_RESET;
      foreach (denom[i]) denom[i] = COIN_RESET[i];
      mismatches = 0;
    endfunction

    function void set_register(logic [SEL_W-1:0] idx, val_t data);
      case (idx)
        REG_COINS_IN_USE: coins_sel = data[SEL_W-1:0];
        REG_COIN_A: denom[0] = data;
        REG_COIN_B: denom[1] = data;
        REG_COIN_C: denom[2] = data;
        REG_COIN_D: denom[3] = data;
        REG_COIN_E: denom[4] = data;
        REG_COIN_F: denom[5] = data;
        default: ;
      endcase
    endfunction

    // full table rebuild for 0..amt, then walk back through the last coins
    function change_t fewest_coins(val_t amt);
      change_t res;
      int n, i, j, m;
      int unsigned c, prev;
      int unsigned used [MAX_COINS];
      res = '0;
      foreach (used[k]) used[k] = 0;
      n = (coins_sel > MAX_COINS) ? MAX_COINS : int'(coins_sel);
      if (amt > MAX_AMOUNT_DEF) begin
        res.unreach = 1'b1;
        return res;
      end
      least_cnt[0] = 0;
      last_coin[0] = 0;
      for (j = 1; j <= amt; j++) begin
        least_cnt[j] = UNSET_COUNT;
        last_coin[j] = 0;
      end
      for (i = 0; i < n; i++) begin
        c = 32'(denom[i]);
        if (c == 0) continue;
        for (j = c; j <= amt; j++) begin
          prev = least_cnt[j - c];
          if (prev == UNSET_COUNT) continue;
          // strict compare keeps the earlier coin on a tie
          if (least_cnt[j] > prev + 1) begin
            least_cnt[j] = prev + 1;
            last_coin[j] = c;
          end
        end
      end
      if (least_cnt[amt] == UNSET_COUNT) begin
        res.unreach = 1'b1;
        return res;
      end
      m = int'(amt);
      while (m > 0) begin
        c = last_coin[m];
        if (c == 0 || c > m) break;
        // every index holding this value gets counted
        for (i = 0; i < n; i++)
          if (denom[i] == c) used[i]++;
        m -= c;
      end
      for (i = 0; i < MAX_COINS; i++)
        res.used[i] = (used[i] > 255) ? 8'd255 : used[i][7:0];
      res.total = (least_cnt[amt] > 255) ? 8'd255 : least_cnt[amt][7:0];
      res.unreach = 1'b0;
      return res;
    endfunction

    function void note_amount(val_t amt);
      pending_change.insert(pending_change.size(), fewest_coins(amt));
    endfunction

    function int pending();
      return pending_change.size();
    endfunction

    function string to_text(change_t r);
      return $sformatf("used %0d %0d %0d %0d %0d %0d total %0d unreachable %0d",
                       r.used[0], r.used[1], r.used[2], r.used[3], r.used[4],
                       r.used[5], r.total, r.unreach);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(change_t got);
      change_t want;
      bit bad;
      if (pending_change.size() == 0) begin
        flag({"result with no transaction pending: ", to_text(got)});
        return;
      end
      want = pending_change.pop_front();
      bad = (got.total !== want.total) || (got.unreach !== want.unreach);
      for (int i = 0; i < MAX_COINS; i++)
        if (got.used[i] !== want.used[i]) bad = 1'b1;
      if (bad)
        flag({"mismatch, expected ", to_text(want), ", got ", to_text(got)});
    endfunction
  endclass

  logic clk, rst, start, busy, wr_en, done, unreachable;
  logic [SEL_W-1:0] wr_index;
  val_t amount, wr_data;
  val_t used_a, used_b, used_c, used_d, used_e, used_f, total_coins;
  int cycle_count;

  coin_change_board board = new();

  min_coin_change_dp_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .amount(amount),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .done(done),
    .used_a(used_a), .used_b(used_b), .used_c(used_c), .used_d(used_d),
    .used_e(used_e), .used_f(used_f), .total_coins(total_coins),
    .unreachable(unreachable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) board.set_register(wr_index, wr_data);
      if (done)
        board.check_result({used_f, used_e, used_d, used_c, used_b, used_a,
                            total_coins, unreachable});
      if (start && !busy) board.note_amount(amount);
    end
  end

  task automatic send_amount(val_t a);
    @(negedge clk);
    start <= 1'b1;
    amount <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      amount <= VAL_W'($urandom);
    end
  endtask

  // lower start and wait until every transaction has produced its result
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [SEL_W-1:0] idx, val_t data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
  endtask

  task automatic write_coins(val_t sel_data, val_t a, val_t b, val_t c,
                             val_t d, val_t e, val_t f);
    write_reg(REG_COINS_IN_USE, sel_data);
    write_reg(REG_COIN_A, a);
    write_reg(REG_COIN_B, b);
    write_reg(REG_COIN_C, c);
    write_reg(REG_COIN_D, d);
    write_reg(REG_COIN_E, e);
    write_reg(REG_COIN_F, f);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // mostly small amounts, since fill time grows with the amount
  function automatic val_t pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return VAL_W'($urandom_range(0, 40));
    if (r < 93) return VAL_W'($urandom_range(0, 255));
    return 8'd255;
  endfunction

  task automatic random_setup();
    int r;
    logic [SEL_W-1:0] sel;
    val_t vals [MAX_COINS];
    r = $urandom_range(0, 99);
    if (r < 70) sel = SEL_W'($urandom_range(1, 6));
    else if (r < 80) sel = 3'd0;
    else if (r < 90) sel = 3'd7;
    else sel = 3'd6;
    for (int k = 0; k < MAX_COINS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) vals[k] = VAL_W'($urandom_range(1, 20));
      else if (r < 75) vals[k] = VAL_W'($urandom_range(1, 64));
      else if (r < 85) vals[k] = VAL_W'($urandom_range(65, 255));
      else if (r < 92) vals[k] = 8'd0;
      else vals[k] = (k == 0) ? VAL_W'($urandom_range(1, 20)) : vals[0];
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, VAL_W'($urandom));
    write_coins({5'($urandom), sel}, vals[0], vals[1], vals[2], vals[3],
                vals[4], vals[5]);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    amount = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset denominations
    send_amount(8'd0);
    send_amount(8'd255);
    send_amount(8'd1);
    idle_gap(2);
    send_amount(8'd30);
    send_amount(8'd44);
    send_amount(8'd128);
    drain_results();

    // coin select of seven acts as six, one zero denomination
    write_coins(8'hFF, 8'd255, 8'd128, 8'd0, 8'd3, 8'd2, 8'd1);
    send_amount(8'd255);
    send_amount(8'd254);
    idle_gap(1);
    send_amount(8'd127);
    send_amount(8'd4);
    drain_results();

    // no coins selected
    write_coins(8'h08, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6);
    send_amount(8'd0);
    send_amount(8'd1);
    send_amount(8'd200);
    drain_results();

    // repeated denominations, counts may exceed the total
    write_coins(8'd6, 8'd5, 8'd5, 8'd5, 8'd9, 8'd5, 8'd9);
    send_amount(8'd3);
    send_amount(8'd14);
    send_amount(8'd255);
    drain_results();

    // all ones at the largest amount
    write_coins(8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_amount(8'd255);
    drain_results();

    // a single large coin, plus a write to the spare index
    write_reg(REG_SPARE, 8'hA5);
    write_coins(8'hF9, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_amount(8'd255);
    send_amount(8'd254);
    send_amount(8'd0);
    drain_results();

    for (int p = 0; p < 9; p++) begin
      random_setup();
      for (int n = 0; n < 30; n++) begin
        send_amount(pick_amount());
        if (p % 3 != 1) idle_gap(gap_len());
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_ram.sv
hw/rtl/mcc_relax.sv
hw/rtl/mcc_tally.sv
hw/rtl/min_coin_change_dp_core.sv
tb/testbench.sv
